@@ hw/rtl/tsc_pkg.sv @@
// Shared types and constants for the touch swipe classifier.
// Used by tsc_ctrl, tsc_dp and touch_swipe_classifier; no dependencies.

package tsc_pkg;

    // Input event encoding
    localparam logic [15:0] EVT_KEY   = 16'd1;
    localparam logic [15:0] EVT_ABS   = 16'd3;
    localparam logic [15:0] AXIS_X    = 16'd0;
    localparam logic [15:0] AXIS_Y    = 16'd1;
    localparam logic [15:0] KEY_TOUCH = 16'd330;
    localparam logic [15:0] AXIS_IDLE = 16'd10;

    // Field widths
    localparam int EVT_W   = 16;
    localparam int SIZE_W  = 12;
    localparam int RANGE_W = 16;
    localparam int OUT_W   = 12;
    localparam int SWIPE_W = 3;
    localparam int PROD_W  = EVT_W + SIZE_W;

    // Swipe codes
    localparam logic [SWIPE_W-1:0] SWIPE_NONE  = 3'd0;
    localparam logic [SWIPE_W-1:0] SWIPE_UP    = 3'd1;
    localparam logic [SWIPE_W-1:0] SWIPE_DOWN  = 3'd2;
    localparam logic [SWIPE_W-1:0] SWIPE_LEFT  = 3'd3;
    localparam logic [SWIPE_W-1:0] SWIPE_RIGHT = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd4;

    // Configuration reset values
    localparam logic [SIZE_W-1:0]  RST_SCREEN_WIDTH  = 12'd800;
    localparam logic [SIZE_W-1:0]  RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [RANGE_W-1:0] RST_RANGE_X       = 16'd800;
    localparam logic [RANGE_W-1:0] RST_RANGE_Y       = 16'd480;
    localparam logic [SIZE_W-1:0]  RST_THRESHOLD     = 12'd80;

    // Controller states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_PREP = 6'b000100,
        S_DIV  = 6'b001000,
        S_WB   = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic prep;
        logic div_step;
        logic write;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scale;
        logic is_release;
        logic special;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/tsc_ctrl.sv @@
// Sequencer for the touch swipe classifier: accept, multiply, divide, write back, emit.
// Depends on tsc_pkg.

module tsc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tsc_pkg::dp_status_t status,
    output tsc_pkg::dp_cmd_t    cmd
);
    import tsc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.need_scale) begin
                        state_next = S_MUL;
                    end else if (status.is_release) begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = status.special ? S_WB : S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_WB;
                end
            end
            S_WB: begin
                cmd.write  = 1'b1;
                state_next = S_IDLE;
            end
            S_EMIT: begin
                // Hold until the output register can take the word
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/tsc_dp.sv @@
// Datapath: config registers, press state, scaling multiplier, shift-subtract divider,
// swipe classification and output register. Depends on tsc_pkg.

module tsc_dp #(
    parameter int COORD_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration
    input  logic                                cfg_valid,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsc_pkg::RANGE_W-1:0]         cfg_data,
    // Input word
    input  logic [tsc_pkg::EVT_W-1:0]           s_event_type,
    input  logic [tsc_pkg::EVT_W-1:0]           s_event_code,
    input  logic [tsc_pkg::EVT_W-1:0]           s_event_value,
    // Output word
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tsc_pkg::SWIPE_W-1:0]         m_swipe_code,
    output logic [tsc_pkg::OUT_W-1:0]           m_end_x,
    output logic [tsc_pkg::OUT_W-1:0]           m_end_y,
    // Control
    input  tsc_pkg::dp_cmd_t                    cmd,
    output tsc_pkg::dp_status_t                 status
);
    import tsc_pkg::*;

    localparam int REM_W = (RANGE_W + COORD_BITS > PROD_W) ? RANGE_W + COORD_BITS : PROD_W;
    localparam int CNT_W = $clog2(COORD_BITS);
    localparam int CMP_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    // Configuration registers
    logic [SIZE_W-1:0]  screen_width_reg;
    logic [SIZE_W-1:0]  screen_height_reg;
    logic [RANGE_W-1:0] range_x_reg;
    logic [RANGE_W-1:0] range_y_reg;
    logic [SIZE_W-1:0]  threshold_reg;

    // Press state
    logic [EVT_W-1:0]      cur_axis_reg;
    logic [COORD_BITS-1:0] pending_x_reg;
    logic [COORD_BITS-1:0] start_x_reg;
    logic [COORD_BITS-1:0] start_y_reg;
    logic                  have_start_reg;
    logic [COORD_BITS-1:0] point_x_reg;
    logic [COORD_BITS-1:0] point_y_reg;

    // Scaling operands and divider
    logic [EVT_W-1:0]      op_raw_reg;
    logic [SIZE_W-1:0]     op_size_reg;
    logic [RANGE_W-1:0]    op_range_reg;
    logic                  pair_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      dvs_reg;
    logic [COORD_BITS-1:0] quo_reg;
    logic [CNT_W-1:0]      cnt_reg;

    // Output register
    logic                  m_valid_reg;
    logic [SWIPE_W-1:0]    swipe_reg;
    logic [OUT_W-1:0]      end_x_reg;
    logic [OUT_W-1:0]      end_y_reg;

    logic                  is_abs;
    logic                  is_x;
    logic                  is_pair;
    logic                  range_zero;
    logic                  saturate;
    logic                  rem_ge;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SWIPE_W-1:0]    swipe_next;

    // Decode the incoming word
    assign is_abs  = (s_event_type == EVT_ABS);
    assign is_x    = is_abs && (s_event_code == AXIS_X);
    assign is_pair = is_abs && (s_event_code == AXIS_Y) && (cur_axis_reg == AXIS_X);

    // Zero range and saturation checks ahead of the divide
    assign range_zero = (op_range_reg == '0);
    assign saturate   = (REM_W'(prod_reg) >= (REM_W'(op_range_reg) << COORD_BITS));
    assign rem_ge     = (rem_reg >= dvs_reg);

    assign status.need_scale = is_x || is_pair;
    assign status.is_release = (s_event_type == EVT_KEY) && (s_event_code == KEY_TOUCH)
                               && (s_event_value == '0);
    assign status.special    = range_zero || saturate;
    assign status.div_last   = (cnt_reg == '0);
    assign status.out_free   = !m_valid_reg || m_ready;

    // Classify the movement of this press
    always_comb begin
        dx = (point_x_reg > start_x_reg) ? point_x_reg - start_x_reg
                                         : start_x_reg - point_x_reg;
        dy = (point_y_reg > start_y_reg) ? point_y_reg - start_y_reg
                                         : start_y_reg - point_y_reg;
        swipe_next = SWIPE_NONE;
        if ((CMP_W'(dx) > CMP_W'(threshold_reg)) || (CMP_W'(dy) > CMP_W'(threshold_reg))) begin
            if (dx > dy) begin
                swipe_next = (point_x_reg > start_x_reg) ? SWIPE_RIGHT : SWIPE_LEFT;
            end else begin
                swipe_next = (point_y_reg > start_y_reg) ? SWIPE_DOWN : SWIPE_UP;
            end
        end
    end

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            range_x_reg       <= RST_RANGE_X;
            range_y_reg       <= RST_RANGE_Y;
            threshold_reg     <= RST_THRESHOLD;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SIZE_W-1:0];
                REG_RANGE_X:       range_x_reg       <= cfg_data;
                REG_RANGE_Y:       range_y_reg       <= cfg_data;
                REG_THRESHOLD:     threshold_reg     <= cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Press state: axis history, pending X, points
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_axis_reg   <= AXIS_IDLE;
            pending_x_reg  <= '0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            have_start_reg <= 1'b0;
            point_x_reg    <= '0;
            point_y_reg    <= '0;
        end else if (cmd.accept && is_abs) begin
            cur_axis_reg  <= s_event_code;
        end else if (cmd.write) begin
            if (pair_reg) begin
                point_x_reg <= pending_x_reg;
                point_y_reg <= quo_reg;
                if (!have_start_reg) begin
                    start_x_reg    <= pending_x_reg;
                    start_y_reg    <= quo_reg;
                    have_start_reg <= 1'b1;
                end
            end else begin
                pending_x_reg <= quo_reg;
            end
        end else if (cmd.emit) begin
            // Clear the press; the last point stays
            cur_axis_reg   <= AXIS_IDLE;
            pending_x_reg  <= '0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            have_start_reg <= 1'b0;
        end
    end

    // Latch operands, multiply, then divide one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_raw_reg   <= s_event_value;
            op_size_reg  <= is_x ? screen_width_reg : screen_height_reg;
            op_range_reg <= is_x ? range_x_reg : range_y_reg;
            pair_reg     <= is_pair;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(op_raw_reg) * PROD_W'(op_size_reg);
        end
        if (cmd.prep) begin
            rem_reg <= REM_W'(prod_reg);
            dvs_reg <= REM_W'(op_range_reg) << (COORD_BITS - 1);
            cnt_reg <= CNT_W'(COORD_BITS - 1);
            if (range_zero) begin
                quo_reg <= '0;
            end else if (saturate) begin
                quo_reg <= COORD_MAX;
            end else begin
                quo_reg <= '0;
            end
        end
        if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - dvs_reg;
            end
            quo_reg <= {quo_reg[COORD_BITS-2:0], rem_ge};
            dvs_reg <= dvs_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            swipe_reg <= swipe_next;
            end_x_reg <= OUT_W'(point_x_reg);
            end_y_reg <= OUT_W'(point_y_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_swipe_code = swipe_reg;
    assign m_end_x      = end_x_reg;
    assign m_end_y      = end_y_reg;

endmodule

@@ hw/rtl/touch_swipe_classifier.sv @@
// Top level of the touch swipe classifier: controller plus datapath.
// Depends on tsc_pkg, tsc_ctrl and tsc_dp.
//
//  Channel  Handshake             Word
//  -------  --------------------  ------------------------------------------
//  input    s_valid / s_ready     s_event_type, s_event_code, s_event_value
//  result   m_valid / m_ready     m_swipe_code, m_end_x, m_end_y
//  config   cfg_valid / cfg_ready cfg_index, cfg_data
//
// An X event, or a Y event that pairs with the X before it, passes through one multiply,
// a range check, one divider step per quotient bit, and a write-back. A zero range or a
// saturated value skips the divider. Other events are taken in the idle state with no
// further step, except a release, which goes on to the emit step and waits there for the output register.
// Reset restores the register defaults and clears the press state at once; cfg_ready is
// always high. The output register lets the next event in while a result waits.

module touch_swipe_classifier #(
    parameter int COORD_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsc_pkg::RANGE_W-1:0]     cfg_data,
    // Input events
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tsc_pkg::EVT_W-1:0]       s_event_type,
    input  logic [tsc_pkg::EVT_W-1:0]       s_event_code,
    input  logic [tsc_pkg::EVT_W-1:0]       s_event_value,
    // Results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tsc_pkg::SWIPE_W-1:0]     m_swipe_code,
    output logic [tsc_pkg::OUT_W-1:0]       m_end_x,
    output logic [tsc_pkg::OUT_W-1:0]       m_end_y
);
    import tsc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tsc_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_event_type  (s_event_type),
        .s_event_code  (s_event_code),
        .s_event_value (s_event_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_swipe_code  (m_swipe_code),
        .m_end_x       (m_end_x),
        .m_end_y       (m_end_y),
        .cmd           (cmd),
        .status        (status)
    );

    // A release word blocks input for at least the following cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_event_type == EVT_KEY) && (s_event_code == KEY_TOUCH)
        && (s_event_value == '0) |=> !s_ready)
        else $error("input taken right after a release");

    // A new result is loaded only while input is held off
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result loaded outside the emit step");

    // Swipe code stays in its defined range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_swipe_code <= SWIPE_RIGHT))
        else $error("swipe code out of range");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for touch_swipe_classifier: directed event table, then random presses.
// Depends on tsc_pkg and the touch_swipe_classifier RTL; holds its own swipe predictor.

module tb_top;
    import tsc_pkg::*;

    localparam int COORD_BITS = 12;
    localparam logic [OUT_W-1:0] COORD_MAX = OUT_W'((1 << COORD_BITS) - 1);
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 2 * (COORD_BITS + 4);
    localparam int PHASES = 8;
    localparam int PHASE_WORDS = 100;
    localparam int DIR_ROWS = 27;
    localparam int SHOW_MAX = 10;

    // Event fields outside the encoded set
    localparam logic [EVT_W-1:0] KEY_RELEASED = 16'd0;
    localparam logic [EVT_W-1:0] KEY_PRESSED  = 16'd1;
    localparam logic [EVT_W-1:0] KEY_OTHER    = KEY_TOUCH + 16'd1;
    localparam logic [EVT_W-1:0] AXIS_OTHER   = 16'd5;
    localparam logic [EVT_W-1:0] TYPE_NONE    = 16'd0;
    localparam logic [EVT_W-1:0] TYPE_ALL     = 16'hFFFF;

    typedef struct packed {
        logic [EVT_W-1:0] etype;
        logic [EVT_W-1:0] ecode;
        logic [EVT_W-1:0] evalue;
    } evt_t;

    typedef struct packed {
        logic [SWIPE_W-1:0] swipe;
        logic [OUT_W-1:0]   x;
        logic [OUT_W-1:0]   y;
    } swipe_res_t;

    typedef struct packed {
        evt_t       ev;
        logic       fixed;
        swipe_res_t res;
    } step_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RANGE_W-1:0]   cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [EVT_W-1:0]     s_event_type;
    logic [EVT_W-1:0]     s_event_code;
    logic [EVT_W-1:0]     s_event_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [SWIPE_W-1:0]   m_swipe_code;
    logic [OUT_W-1:0]     m_end_x;
    logic [OUT_W-1:0]     m_end_y;

    touch_swipe_classifier #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_event_type (s_event_type),
        .s_event_code (s_event_code),
        .s_event_value(s_event_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_swipe_code (m_swipe_code),
        .m_end_x      (m_end_x),
        .m_end_y      (m_end_y)
    );

    // Predictor copy of the configuration
    logic [SIZE_W-1:0]  cfg_w   = RST_SCREEN_WIDTH;
    logic [SIZE_W-1:0]  cfg_h   = RST_SCREEN_HEIGHT;
    logic [RANGE_W-1:0] cfg_rx  = RST_RANGE_X;
    logic [RANGE_W-1:0] cfg_ry  = RST_RANGE_Y;
    logic [SIZE_W-1:0]  cfg_thr = RST_THRESHOLD;

    // Predictor copy of the press state
    logic [EVT_W-1:0] hist_prev  = AXIS_IDLE;
    logic [EVT_W-1:0] hist_cur   = AXIS_IDLE;
    logic [OUT_W-1:0] x_pending  = '0;
    logic [OUT_W-1:0] press_x0   = '0;
    logic [OUT_W-1:0] press_y0   = '0;
    logic             press_open = 1'b0;
    logic [OUT_W-1:0] last_x     = '0;
    logic [OUT_W-1:0] last_y     = '0;

    swipe_res_t release_q[$];
    int         fault_count = 0;
    int         live_words = 0;
    int         cycles = 0;
    bit         steady = 1'b0;

    // Directed events; typed results only where they follow at a glance
    step_row_t dir_rows [DIR_ROWS] = '{
        '{'{EVT_KEY, KEY_TOUCH, KEY_RELEASED}, 1'b1, '{SWIPE_NONE, 12'd0, 12'd0}},
        '{'{EVT_KEY, KEY_TOUCH, KEY_PRESSED}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_X, 16'd100}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_Y, 16'd100}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_X, 16'd300}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_Y, 16'd120}, 1'b0, '0},
        '{'{EVT_KEY, KEY_TOUCH, KEY_RELEASED}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_X, 16'hFFFF}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_Y, 16'hFFFF}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_X, 16'd0}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_OTHER, 16'd0}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_Y, 16'd0}, 1'b0, '0},
        '{'{EVT_KEY, KEY_TOUCH, KEY_RELEASED}, 1'b1, '{SWIPE_NONE, COORD_MAX, COORD_MAX}},
        '{'{TYPE_NONE, 16'd0, 16'd0}, 1'b0, '0},
        '{'{TYPE_ALL, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{EVT_KEY, KEY_OTHER, KEY_RELEASED}, 1'b0, '0},
        '{'{EVT_KEY, KEY_TOUCH, KEY_RELEASED}, 1'b1, '{SWIPE_DOWN, COORD_MAX, COORD_MAX}},
        '{'{EVT_ABS, AXIS_X, 16'd500}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_Y, 16'd400}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_X, 16'd500}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_Y, 16'd200}, 1'b0, '0},
        '{'{EVT_KEY, KEY_TOUCH, KEY_RELEASED}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_X, 16'd400}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_Y, 16'd50}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_X, 16'd100}, 1'b0, '0},
        '{'{EVT_ABS, AXIS_Y, 16'd60}, 1'b0, '0},
        '{'{EVT_KEY, KEY_TOUCH, KEY_RELEASED}, 1'b0, '0}
    };

    always #10 aclk = ~aclk;

    // Scale a raw panel coordinate to pixels, saturating at the coordinate maximum
    function automatic logic [OUT_W-1:0] scale_px(input logic [EVT_W-1:0] raw,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic [RANGE_W-1:0] span);
        logic [PROD_W-1:0] quot;
        if (span == '0)
            return '0;
        quot = (PROD_W'(raw) * PROD_W'(size)) / PROD_W'(span);
        if (quot > PROD_W'(COORD_MAX))
            return COORD_MAX;
        return quot[OUT_W-1:0];
    endfunction

    // Advance the press state by one event; flag a result on a touch release
    task automatic classify_event(input evt_t ev, output logic fired, output swipe_res_t r);
        logic [OUT_W-1:0] dx;
        logic [OUT_W-1:0] dy;
        fired = 1'b0;
        r = '0;
        if (ev.etype == EVT_ABS) begin
            hist_prev = hist_cur;
            hist_cur = ev.ecode;
            if (ev.ecode == AXIS_X)
                x_pending = scale_px(ev.evalue, cfg_w, cfg_rx);
            if (hist_prev == AXIS_X && hist_cur == AXIS_Y) begin
                last_x = x_pending;
                last_y = scale_px(ev.evalue, cfg_h, cfg_ry);
                if (!press_open) begin
                    press_x0 = last_x;
                    press_y0 = last_y;
                    press_open = 1'b1;
                end
            end
        end else if (ev.etype == EVT_KEY && ev.ecode == KEY_TOUCH
                     && ev.evalue == KEY_RELEASED) begin
            dx = (last_x > press_x0) ? last_x - press_x0 : press_x0 - last_x;
            dy = (last_y > press_y0) ? last_y - press_y0 : press_y0 - last_y;
            r.swipe = SWIPE_NONE;
            // dominant axis wins; a tie goes vertical
            if (dx > cfg_thr || dy > cfg_thr) begin
                if (dx > dy)
                    r.swipe = (last_x > press_x0) ? SWIPE_RIGHT : SWIPE_LEFT;
                else
                    r.swipe = (last_y > press_y0) ? SWIPE_DOWN : SWIPE_UP;
            end
            r.x = last_x;
            r.y = last_y;
            fired = 1'b1;
            hist_prev = AXIS_IDLE;
            hist_cur = AXIS_IDLE;
            x_pending = '0;
            press_x0 = '0;
            press_y0 = '0;
            press_open = 1'b0;
        end
    endtask

    // Offer one word, hold it until accepted, then record what it should produce
    task automatic send_word(input evt_t ev, input logic fixed, input swipe_res_t typed);
        logic       fired;
        swipe_res_t pred;
        int         gap;
        @(negedge aclk);
        if (!steady && $urandom_range(0, 99) < 34) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_event_type = ev.etype;
        s_event_code = ev.ecode;
        s_event_value = ev.evalue;
        do @(posedge aclk); while (!s_ready);
        classify_event(ev, fired, pred);
        if (fired)
            release_q.push_back(fixed ? typed : pred);
        live_words++;
    endtask

    // Drop valid and wait for every expected result, then hold off
    task automatic wait_idle(input int extra);
        @(negedge aclk);
        s_valid = 1'b0;
        while (release_q.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // Write one register and mirror it in the predictor
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [RANGE_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SCREEN_WIDTH:  cfg_w = data[SIZE_W-1:0];
            REG_SCREEN_HEIGHT: cfg_h = data[SIZE_W-1:0];
            REG_RANGE_X:       cfg_rx = data;
            REG_RANGE_Y:       cfg_ry = data;
            REG_THRESHOLD:     cfg_thr = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // Raw coordinate: mostly inside the panel range, sometimes anything
    function automatic logic [EVT_W-1:0] pick_raw(input logic [RANGE_W-1:0] span);
        if (span == '0 || $urandom_range(0, 9) == 0)
            return EVT_W'($urandom);
        return EVT_W'($urandom_range(0, span));
    endfunction

    function automatic evt_t noise_word();
        evt_t e;
        e.etype = EVT_W'($urandom);
        e.ecode = EVT_W'($urandom);
        e.evalue = EVT_W'($urandom);
        case ($urandom_range(0, 2))
            0: begin
                e.etype = EVT_ABS;
                if ($urandom_range(0, 1))
                    e.ecode = EVT_W'($urandom_range(0, 3));
            end
            1: begin
                e.etype = EVT_KEY;
                if ($urandom_range(0, 1))
                    e.ecode = KEY_TOUCH;
            end
            default: ;
        endcase
        return e;
    endfunction

    // Mostly a full press with random points, otherwise a broken or noisy sequence
    task automatic random_sequence();
        int pairs;
        if ($urandom_range(0, 99) < 80) begin
            send_word('{EVT_KEY, KEY_TOUCH, EVT_W'($urandom_range(1, 65535))}, 1'b0, '0);
            pairs = $urandom_range(1, 5);
            repeat (pairs) begin
                if ($urandom_range(0, 99) < 10)
                    send_word(noise_word(), 1'b0, '0);
                send_word('{EVT_ABS, AXIS_X, pick_raw(cfg_rx)}, 1'b0, '0);
                send_word('{EVT_ABS, AXIS_Y, pick_raw(cfg_ry)}, 1'b0, '0);
            end
            send_word('{EVT_KEY, KEY_TOUCH, KEY_RELEASED}, 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 3))
                    0: send_word(noise_word(), 1'b0, '0);
                    1: send_word('{EVT_ABS, AXIS_X, pick_raw(cfg_rx)}, 1'b0, '0);
                    2: send_word('{EVT_ABS, AXIS_Y, pick_raw(cfg_ry)}, 1'b0, '0);
                    default: send_word('{EVT_KEY, KEY_TOUCH, KEY_RELEASED}, 1'b0, '0);
                endcase
            end
        end
    endtask

    // Stall the result channel at random, except in the steady stretch
    always @(negedge aclk) begin
        m_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin : result_check
        swipe_res_t want;
        swipe_res_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_swipe_code, m_end_x, m_end_y};
            if (release_q.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_MAX)
                    $display("unexpected result: swipe %0d x %0d y %0d",
                             got.swipe, got.x, got.y);
            end else begin
                want = release_q.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= SHOW_MAX)
                        $display("mismatch: expected swipe %0d x %0d y %0d, got swipe %0d x %0d y %0d",
                                 want.swipe, want.x, want.y, got.swipe, got.x, got.y);
                end
            end
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic [SIZE_W-1:0]  thr;
        logic [RANGE_W-1:0] rx;
        logic [RANGE_W-1:0] ry;
        int                 phase_base;
        bit                 paused;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_event_type = '0;
        s_event_code = '0;
        s_event_value = '0;
        paused = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table
        foreach (dir_rows[i])
            send_word(dir_rows[i].ev, dir_rows[i].fixed, dir_rows[i].res);

        // Random phases, each under its own setting
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_idle(HOLD_CYCLES);
                w = SIZE_W'($urandom_range(1, 4095));
                h = SIZE_W'($urandom_range(1, 4095));
                rx = ($urandom_range(0, 3) == 0) ? RANGE_W'($urandom_range(1, 65535))
                                                 : RANGE_W'($urandom_range(1, 4095));
                ry = ($urandom_range(0, 3) == 0) ? RANGE_W'($urandom_range(1, 65535))
                                                 : RANGE_W'($urandom_range(1, 4095));
                thr = SIZE_W'($urandom_range(0, 300));
                case (p)
                    1: begin
                        w = 12'd4095;
                        h = 12'd4095;
                        rx = 16'hFFFF;
                        ry = 16'hFFFF;
                        thr = 12'd0;
                    end
                    2: begin
                        w = 12'd1;
                        h = 12'd1;
                        rx = 16'd1;
                        ry = 16'd1;
                        thr = 12'd4095;
                    end
                    3: begin
                        rx = '0;
                        ry = '0;
                    end
                    default: ;
                endcase
                // upper data bits of the 12-bit registers carry junk
                cfg_put(REG_SCREEN_WIDTH, {4'($urandom), w});
                cfg_put(REG_SCREEN_HEIGHT, {4'($urandom), h});
                cfg_put(REG_RANGE_X, rx);
                cfg_put(REG_RANGE_Y, ry);
                cfg_put(REG_THRESHOLD, {4'($urandom), thr});
                if (p >= 4)
                    cfg_put(CFG_IDX_W'(REG_THRESHOLD + 1 + $urandom_range(0, 2)),
                            RANGE_W'($urandom));
                @(negedge aclk);
                cfg_valid = 1'b0;
            end
            steady = (p == 5);
            phase_base = live_words;
            while (live_words - phase_base < PHASE_WORDS) begin
                if (p == 4 && !paused && live_words - phase_base >= PHASE_WORDS / 2) begin
                    wait_idle(0);
                    paused = 1'b1;
                end
                random_sequence();
            end
        end
        steady = 1'b0;

        // Drain and report
        wait_idle(HOLD_CYCLES);
        if (fault_count == 0 && release_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
